// ===== hdl/movdec_pkg.sv =====
// ----------------------------------------------------------------------------
// movdec_pkg
// Shared codes, result type and opcode helpers for the MOV field decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package movdec_pkg;

  // Instruction form codes
  localparam logic [2:0] FORM_RMREG  = 3'd0;  // 100010dw
  localparam logic [2:0] FORM_IMMRM  = 3'd1;  // 1100011w
  localparam logic [2:0] FORM_IMMREG = 3'd2;  // 1011wrrr
  localparam logic [2:0] FORM_MEMACC = 3'd3;  // 1010000w
  localparam logic [2:0] FORM_ACCMEM = 3'd4;  // 1010001w
  localparam logic [2:0] FORM_UNSUP  = 3'd5;

  // Addressing byte field masks
  localparam logic [7:0] MODRM_MOD_MASK = 8'b1100_0000;
  localparam logic [7:0] MODRM_REG_MASK = 8'b0011_1000;
  localparam logic [7:0] MODRM_RM_MASK  = 8'b0000_0111;
  localparam logic [2:0] RM_DIRECT      = 3'b110;

  localparam logic [1:0] MOD_NO_DISP = 2'b00;
  localparam logic [1:0] MOD_DISP8   = 2'b01;
  localparam logic [1:0] MOD_DISP16  = 2'b10;

  typedef struct packed {
    logic [2:0]  form;
    logic        wide_flag;
    logic        dir_flag;
    logic [1:0]  mode_bits;
    logic [2:0]  reg_bits;
    logic [2:0]  rm_bits;
    logic [15:0] displacement;
    logic [15:0] data_word;
    logic [2:0]  length_bytes;
  } movdec_res_t;

  function automatic logic [2:0] form_of(input logic [7:0] op);
    logic [2:0] f;
    if (op[7:2] == 6'b100010)       f = FORM_RMREG;
    else if (op[7:1] == 7'b1100011) f = FORM_IMMRM;
    else if (op[7:4] == 4'b1011)    f = FORM_IMMREG;
    else if (op[7:1] == 7'b1010000) f = FORM_MEMACC;
    else if (op[7:1] == 7'b1010001) f = FORM_ACCMEM;
    else                            f = FORM_UNSUP;
    return f;
  endfunction

  // Displacement byte count implied by the addressing byte
  function automatic logic [1:0] disp_len(input logic [7:0] modrm);
    logic [1:0] m;
    logic [2:0] r;
    logic [1:0] n;
    m = modrm[7:6];
    r = modrm[2:0];
    unique case (m)
      MOD_NO_DISP: n = (r == RM_DIRECT) ? 2'd2 : 2'd0;
      MOD_DISP8:   n = 2'd1;
      MOD_DISP16:  n = 2'd2;
      default:     n = 2'd0;
    endcase
    return n;
  endfunction

  // Immediate / address byte count implied by the opcode
  function automatic logic [1:0] data_len(input logic [7:0] op);
    logic [1:0] n;
    unique case (form_of(op))
      FORM_IMMRM:               n = op[0] ? 2'd2 : 2'd1;
      FORM_IMMREG:              n = op[3] ? 2'd2 : 2'd1;
      FORM_MEMACC, FORM_ACCMEM: n = 2'd2;
      default:                  n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/movdec_fmt.sv =====
// ----------------------------------------------------------------------------
// movdec_fmt
// Builds one decoded result from the latched instruction bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module movdec_fmt
  import movdec_pkg::*;
(
  input  wire logic [7:0]  opcode,
  input  wire logic [7:0]  modrm,
  input  wire logic [15:0] disp,
  input  wire logic [15:0] data,
  input  wire logic [2:0]  count,
  output movdec_res_t      res
);

  logic [2:0] f;

  assign f = form_of(opcode);

  // Fields that do not apply to a form stay zero
  always_comb begin
    res              = '0;
    res.form         = f;
    res.length_bytes = count;
    unique case (f)
      FORM_RMREG, FORM_IMMRM: begin
        res.wide_flag    = opcode[0];
        res.mode_bits    = 2'((modrm & MODRM_MOD_MASK) >> 6);
        res.reg_bits     = 3'((modrm & MODRM_REG_MASK) >> 3);
        res.rm_bits      = 3'(modrm & MODRM_RM_MASK);
        res.displacement = disp;
        if (f == FORM_RMREG) begin
          res.dir_flag = opcode[1];
        end else begin
          res.data_word = data;
        end
      end
      FORM_IMMREG: begin
        res.wide_flag = opcode[3];
        res.reg_bits  = opcode[2:0];
        res.data_word = data;
      end
      FORM_MEMACC, FORM_ACCMEM: begin
        res.wide_flag = opcode[0];
        res.data_word = data;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/mov_instruction_field_decoder.sv =====
// ----------------------------------------------------------------------------
// mov_instruction_field_decoder
// Byte-serial decoder for the 16-bit x86 MOV encodings without segment regs.
// ----------------------------------------------------------------------------
// One code byte is taken per item; a result item comes out on the cycle after
// the last byte of an instruction arrives, one per instruction, and a
// non-MOV opcode yields an unsupported result right away (length 1). The
// block sustains one item per clock: each byte only updates the phase and
// the byte latches, and the result goes into an output register, so a new
// byte is taken whenever that register is empty or being drained in the same
// cycle. in_ready drops only while a result waits on a low out_ready.
// Bytes per instruction: 1 to 6 (opcode, addressing byte, 0-2 displacement
// bytes, 0-2 immediate/address bytes, little-endian). One-byte displacement
// and one-byte immediate are zero-extended.
// ----------------------------------------------------------------------------
`default_nettype none

module mov_instruction_field_decoder
  import movdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream in
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_code_byte,
  // decoded instruction out
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [2:0]  out_form,
  output      logic        out_wide_flag,
  output      logic        out_dir_flag,
  output      logic [1:0]  out_mode_bits,
  output      logic [2:0]  out_reg_bits,
  output      logic [2:0]  out_rm_bits,
  output      logic [15:0] out_displacement,
  output      logic [15:0] out_data_word,
  output      logic [2:0]  out_length_bytes
);

  // Phase codes
  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_MODRM   = 3'd1;
  localparam logic [2:0] PH_DISP_LO = 3'd2;
  localparam logic [2:0] PH_DISP_HI = 3'd3;
  localparam logic [2:0] PH_DATA_LO = 3'd4;
  localparam logic [2:0] PH_DATA_HI = 3'd5;

  logic [2:0]  phase_r,  phase_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  modrm_r,  modrm_nxt;
  logic [15:0] disp_r,   disp_nxt;
  logic [15:0] data_r,   data_nxt;
  logic [2:0]  count_r,  count_nxt;

  logic        out_valid_r, out_valid_nxt;
  movdec_res_t res_r;
  movdec_res_t res_nxt;

  logic        in_acc;
  logic        emit;      // this byte completes an instruction
  logic [2:0]  f_in;
  logic [2:0]  count_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign f_in      = form_of(in_code_byte);
  assign count_inc = count_r + 3'd1;

  // Next phase and latch values for an accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    data_nxt   = data_r;
    count_nxt  = count_r;
    emit       = 1'b0;
    unique case (phase_r)
      PH_MODRM: begin
        modrm_nxt = in_code_byte;
        count_nxt = count_inc;
        if (disp_len(in_code_byte) != 2'd0) begin
          phase_nxt = PH_DISP_LO;
        end else if (data_len(opcode_r) != 2'd0) begin
          phase_nxt = PH_DATA_LO;
        end else begin
          emit = 1'b1;
        end
      end
      PH_DISP_LO: begin
        disp_nxt  = {8'h00, in_code_byte};
        count_nxt = count_inc;
        if (disp_len(modrm_r) == 2'd2) begin
          phase_nxt = PH_DISP_HI;
        end else if (data_len(opcode_r) != 2'd0) begin
          phase_nxt = PH_DATA_LO;
        end else begin
          emit = 1'b1;
        end
      end
      PH_DISP_HI: begin
        disp_nxt  = {in_code_byte, disp_r[7:0]};
        count_nxt = count_inc;
        if (data_len(opcode_r) != 2'd0) begin
          phase_nxt = PH_DATA_LO;
        end else begin
          emit = 1'b1;
        end
      end
      PH_DATA_LO: begin
        data_nxt  = {8'h00, in_code_byte};
        count_nxt = count_inc;
        if (data_len(opcode_r) == 2'd2) begin
          phase_nxt = PH_DATA_HI;
        end else begin
          emit = 1'b1;
        end
      end
      PH_DATA_HI: begin
        data_nxt  = {in_code_byte, data_r[7:0]};
        count_nxt = count_inc;
        emit      = 1'b1;
      end
      default: begin
        // opcode byte (unused codes land here too)
        opcode_nxt = in_code_byte;
        modrm_nxt  = '0;
        disp_nxt   = '0;
        data_nxt   = '0;
        count_nxt  = 3'd1;
        if (f_in == FORM_UNSUP) begin
          emit = 1'b1;
        end else if (f_in == FORM_RMREG || f_in == FORM_IMMRM) begin
          phase_nxt = PH_MODRM;
        end else begin
          phase_nxt = PH_DATA_LO;
        end
      end
    endcase
    if (emit) begin
      phase_nxt = PH_OPCODE;
    end
  end

  // Result fields are formed from the post-update latches
  movdec_fmt u_fmt (
    .opcode (opcode_nxt),
    .modrm  (modrm_nxt),
    .disp   (disp_nxt),
    .data   (data_nxt),
    .count  (count_nxt),
    .res    (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      opcode_r    <= '0;
      modrm_r     <= '0;
      disp_r      <= '0;
      data_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r  <= phase_nxt;
        opcode_r <= opcode_nxt;
        modrm_r  <= modrm_nxt;
        disp_r   <= disp_nxt;
        data_r   <= data_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_form         = res_r.form;
  assign out_wide_flag    = res_r.wide_flag;
  assign out_dir_flag     = res_r.dir_flag;
  assign out_mode_bits    = res_r.mode_bits;
  assign out_reg_bits     = res_r.reg_bits;
  assign out_rm_bits      = res_r.rm_bits;
  assign out_displacement = res_r.displacement;
  assign out_data_word    = res_r.data_word;
  assign out_length_bytes = res_r.length_bytes;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.length_bytes >= 3'd1 && res_r.length_bytes <= 3'd6))
    else $error("result length out of range");

  a_unsup_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.form == FORM_UNSUP) |-> (res_r.length_bytes == 3'd1))
    else $error("unsupported opcode must take one byte");

  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> (phase_r == PH_OPCODE && out_valid_r))
    else $error("completed instruction did not return to opcode phase");

  a_opcode_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_OPCODE) |=> (count_r == 3'd1))
    else $error("byte count not restarted on opcode");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

`default_nettype wire
